### hdl/kwm_pkg.sv
// Shared types, constants and helpers for the k-mer window minimizer select unit.
// No dependencies; compile first.
`default_nettype none

package kwm_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int KMER_BITS_DEF  = 64;
    localparam int POS_BITS_DEF   = 32;

    localparam int KMER_W     = 64;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int KLEN_W     = 6;
    localparam int WSIZE_W    = 6;
    localparam int MODE_W     = 2;

    localparam logic [KLEN_W-1:0]  KLEN_RST  = 6'd16;
    localparam logic [WSIZE_W-1:0] WSIZE_RST = 6'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMER_LENGTH = 2'd0,
        REG_WINDOW_SIZE = 2'd1,
        REG_SELECT_MODE = 2'd2
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIXED     = 2'd0,
        MODE_MIN_RIGHT = 2'd1,
        MODE_MIN_ALL   = 2'd2
    } sel_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic recalc;
        logic advance;
        logic restart;
    } phase_ctrl_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } phase_stat_t;

    function automatic logic [6:0] eff_window(input logic [WSIZE_W-1:0] w, input int max_w);
        logic [6:0] wx;
        wx = {1'b0, w};
        if (w == '0)
            return 7'd1;
        if (wx > 7'(max_w))
            return 7'(max_w);
        return wx;
    endfunction

endpackage

`default_nettype wire

### hdl/kwm_ifs.sv
// Valid/ready channel interfaces: k-mer requests, seed results, register writes.
// Depends on kwm_pkg.
`default_nettype none

interface kwm_kmer_if;
    import kwm_pkg::*;
    logic              valid;
    logic              ready;
    logic [KMER_W-1:0] kmer_value;
    logic              starts_sequence;
    logic              ends_sequence;

    modport source (output valid, kmer_value, starts_sequence, ends_sequence, input ready);
    modport sink   (input valid, kmer_value, starts_sequence, ends_sequence, output ready);
endinterface

interface kwm_seed_if;
    import kwm_pkg::*;
    logic              valid;
    logic              ready;
    logic [KMER_W-1:0] seed_value;
    logic [POS_W-1:0]  seed_position;
    logic              last_of_run;

    modport source (output valid, seed_value, seed_position, last_of_run, input ready);
    modport sink   (input valid, seed_value, seed_position, last_of_run, output ready);
endinterface

interface kwm_cfg_if;
    import kwm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/kwm_cell.sv
// One window slot: k-mer value, position, valid and sent marks, prefix minimum.
// Depends on kwm_pkg.
`default_nettype none

module kwm_cell #(
    parameter int KMER_BITS = kwm_pkg::KMER_BITS_DEF,
    parameter int POS_BITS  = kwm_pkg::POS_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kwm_pkg::cell_ctrl_t  ctrl,
    input  wire logic [KMER_BITS-1:0] head_value,
    input  wire logic [KMER_BITS-1:0] prev_value,
    input  wire logic [KMER_BITS-1:0] prev_pmin,
    input  wire logic [POS_BITS-1:0]  prev_pos,
    input  wire logic                 prev_valid,
    input  wire logic                 prev_sent,
    input  wire logic                 mark,
    output logic [KMER_BITS-1:0]      value,
    output logic [KMER_BITS-1:0]      pmin,
    output logic [POS_BITS-1:0]       pos,
    output logic                      valid,
    output logic                      sent
);
    import kwm_pkg::*;

    logic [KMER_BITS-1:0] value_reg;
    logic [KMER_BITS-1:0] pmin_reg;
    logic [KMER_BITS-1:0] pmin_next;
    logic [POS_BITS-1:0]  pos_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 sent_reg;
    logic                 sent_next;

    always_comb
    begin
        pmin_next  = (head_value < prev_pmin) ? head_value : prev_pmin;
        valid_next = valid_reg;
        sent_next  = sent_reg;
        if (ctrl.shift)
        begin
            valid_next = prev_valid;
            sent_next  = prev_sent;
        end
        else if (mark)
        begin
            sent_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= prev_value;
            pmin_reg  <= pmin_next;
            pos_reg   <= prev_pos;
        end
    end

    assign value = value_reg;
    assign pmin  = pmin_reg;
    assign pos   = pos_reg;
    assign valid = valid_reg;
    assign sent  = sent_reg;

endmodule

`default_nettype wire

### hdl/kwm_phase.sv
// Position counter and fixed-interval phase, (pos + k - 1) mod w, with a
// bit-serial remainder unit that rebuilds the phase after reset or a k/w write.
// Depends on kwm_pkg.
`default_nettype none

module kwm_phase #(
    parameter int MAX_WINDOW = kwm_pkg::MAX_WINDOW_DEF,
    parameter int POS_BITS   = kwm_pkg::POS_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kwm_pkg::phase_ctrl_t         ctrl,
    input  wire logic [kwm_pkg::KLEN_W-1:0]   kmer_length,
    input  wire logic [kwm_pkg::WSIZE_W-1:0]  window_size,
    output logic [POS_BITS-1:0]               item_pos,
    output kwm_pkg::phase_stat_t              stat
);
    import kwm_pkg::*;

    localparam int WW     = $clog2(MAX_WINDOW + 1);
    localparam int SH_W   = KLEN_W + POS_BITS;
    localparam int STEP_W = $clog2(SH_W + 1);
    localparam logic [STEP_W-1:0] STEP_BASE = STEP_W'(KLEN_W - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SH_W - 1);

    logic [POS_BITS-1:0] pos_reg,     pos_next;
    logic [WW-1:0]       phase_reg,   phase_next;
    logic [WW-1:0]       base_reg,    base_next;
    logic [WW-1:0]       rem_reg,     rem_next;
    logic [SH_W-1:0]     sh_reg,      sh_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic                run_reg,     run_next;
    logic                pending_reg, pending_next;

    logic [WW-1:0]       w_eff;
    logic [KLEN_W-1:0]   km1;
    logic [WW:0]         trial;
    logic [WW-1:0]       rem_step;
    logic [WW:0]         sum;
    logic [WW-1:0]       phase_calc;
    logic [POS_BITS-1:0] pos_cur;
    logic [WW-1:0]       ph_cur;
    logic [WW:0]         ph_inc;
    logic [WW-1:0]       ph_adv;
    logic                load;

    always_comb
    begin
        w_eff      = WW'(eff_window(window_size, MAX_WINDOW));
        km1        = (kmer_length == '0) ? '0 : kmer_length - KLEN_W'(1);
        trial      = {rem_reg, sh_reg[SH_W-1]};
        rem_step   = (trial >= {1'b0, w_eff}) ? WW'(trial - {1'b0, w_eff}) : WW'(trial);
        sum        = {1'b0, rem_step} + {1'b0, base_reg};
        phase_calc = (sum >= {1'b0, w_eff}) ? WW'(sum - {1'b0, w_eff}) : WW'(sum);
        pos_cur    = ctrl.restart ? '0 : pos_reg;
        ph_cur     = ctrl.restart ? base_reg : phase_reg;
        ph_inc     = {1'b0, ph_cur} + (WW+1)'(1);
        ph_adv     = (ph_inc == {1'b0, w_eff}) ? '0 : WW'(ph_inc);
        load       = pending_reg | ctrl.recalc;

        pos_next     = pos_reg;
        phase_next   = phase_reg;
        base_next    = base_reg;
        rem_next     = rem_reg;
        sh_next      = sh_reg;
        step_next    = step_reg;
        run_next     = run_reg;
        pending_next = pending_reg;

        if (load)
        begin
            sh_next      = {km1, pos_reg};
            rem_next     = '0;
            step_next    = '0;
            run_next     = 1'b1;
            pending_next = 1'b0;
        end
        else if (run_reg)
        begin
            sh_next   = sh_reg << 1;
            step_next = step_reg + STEP_W'(1);
            rem_next  = rem_step;
            if (step_reg == STEP_BASE)
            begin
                base_next = rem_step;
                rem_next  = '0;
            end
            if (step_reg == STEP_LAST)
            begin
                phase_next = phase_calc;
                run_next   = 1'b0;
            end
        end

        if (ctrl.advance)
        begin
            pos_next   = pos_cur + POS_BITS'(1);
            phase_next = (pos_cur == '1) ? base_reg : ph_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= '0;
            base_reg    <= '0;
            step_reg    <= '0;
            run_reg     <= 1'b0;
            pending_reg <= 1'b1;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            base_reg    <= base_next;
            step_reg    <= step_next;
            run_reg     <= run_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign item_pos  = pos_cur;
    assign stat.busy = pending_reg | run_reg;
    assign stat.hit  = (ph_cur == '0);

endmodule

`default_nettype wire

### hdl/kmer_window_minimizer_select_unit.sv
// Top level: window cell chain with prefix minimums, phase unit, seed scan, output register.
// A request's first seed enters the output register after the EVAL and SCAN states; a full
// output register with seed.ready low holds the scan. A new request is accepted only in IDLE,
// after the scan of the last one; the scan emits one seed per cycle while the output is free.
// Reset: clears cell valid and sent marks; input is held after reset and after each
// kmer_length or window_size write while the phase unit rebuilds the phase.
`default_nettype none

module kmer_window_minimizer_select_unit #(
    parameter int MAX_WINDOW = kwm_pkg::MAX_WINDOW_DEF,
    parameter int KMER_BITS  = kwm_pkg::KMER_BITS_DEF,
    parameter int POS_BITS   = kwm_pkg::POS_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    kwm_kmer_if.sink   kmer,
    kwm_seed_if.source seed,
    kwm_cfg_if.sink    cfg
);
    import kwm_pkg::*;

    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);

    logic [KLEN_W-1:0]  kmer_length_reg;
    logic [WSIZE_W-1:0] window_size_reg;
    logic [MODE_W-1:0]  select_mode_reg;
    logic               cfg_wr;

    state_t state_reg, state_next;
    logic   open_reg,  open_next;

    logic                  en_reg;
    logic                  hit_reg;
    logic                  short_ok_reg;
    logic [IDX_W-1:0]      short_idx_reg;
    logic [MAX_WINDOW-1:0] sel_reg, sel_next;

    logic                  out_valid_reg, out_valid_next;
    logic [KMER_W-1:0]     seed_value_reg;
    logic [POS_W-1:0]      seed_position_reg;
    logic                  seed_last_reg;

    logic                  kmer_acc;
    logic                  restart;
    logic [KMER_BITS-1:0]  new_value;
    logic [POS_BITS-1:0]   item_pos;
    phase_ctrl_t           phase_ctrl;
    phase_stat_t           phase_stat;
    cell_ctrl_t            cell_ctrl;

    logic [KMER_BITS-1:0]  cell_value [MAX_WINDOW];
    logic [KMER_BITS-1:0]  cell_pmin  [MAX_WINDOW];
    logic [POS_BITS-1:0]   cell_pos   [MAX_WINDOW];
    logic [KMER_BITS-1:0]  link_value [MAX_WINDOW];
    logic [KMER_BITS-1:0]  link_pmin  [MAX_WINDOW];
    logic [POS_BITS-1:0]   link_pos   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] link_valid;
    logic [MAX_WINDOW-1:0] link_sent;
    logic [MAX_WINDOW-1:0] valid_vec;
    logic [MAX_WINDOW-1:0] sent_vec;
    logic [MAX_WINDOW-1:0] mark_vec;

    logic [WW-1:0]         w_eff;
    logic [IDX_W-1:0]      w_idx;
    logic [KMER_BITS-1:0]  wmin;
    logic [MAX_WINDOW-1:0] eq;
    logic [MAX_WINDOW-1:0] eq_low;
    logic [MAX_WINDOW-1:0] cand;
    logic [IDX_W-1:0]      pick_idx;
    logic                  out_free;
    logic                  emit;
    logic                  emit_last;

    // configuration
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KLEN_RST;
            window_size_reg <= WSIZE_RST;
            select_mode_reg <= MODE_MIN_RIGHT;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                REG_KMER_LENGTH: kmer_length_reg <= cfg.data[KLEN_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg.data[WSIZE_W-1:0];
                REG_SELECT_MODE: select_mode_reg <= cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // request intake
    assign kmer.ready = (state_reg == ST_IDLE) & ~phase_stat.busy & ~cfg.valid;
    assign kmer_acc   = kmer.valid & kmer.ready;
    assign restart    = kmer.starts_sequence | ~open_reg;
    assign new_value  = kmer.kmer_value[KMER_BITS-1:0];

    assign phase_ctrl.recalc  = cfg_wr & ((cfg.index == REG_KMER_LENGTH) |
                                          (cfg.index == REG_WINDOW_SIZE));
    assign phase_ctrl.advance = kmer_acc;
    assign phase_ctrl.restart = restart;

    kwm_phase #(
        .MAX_WINDOW (MAX_WINDOW),
        .POS_BITS   (POS_BITS)
    ) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (phase_ctrl),
        .kmer_length (kmer_length_reg),
        .window_size (window_size_reg),
        .item_pos    (item_pos),
        .stat        (phase_stat)
    );

    // window chain
    assign cell_ctrl.shift = kmer_acc;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign link_value[i] = new_value;
            assign link_pmin[i]  = new_value;
            assign link_pos[i]   = item_pos;
            assign link_valid[i] = 1'b1;
            assign link_sent[i]  = 1'b0;
        end
        else
        begin : g_body
            assign link_value[i] = cell_value[i-1];
            assign link_pmin[i]  = cell_pmin[i-1];
            assign link_pos[i]   = cell_pos[i-1];
            assign link_valid[i] = valid_vec[i-1] & ~restart;
            assign link_sent[i]  = sent_vec[i-1] & ~restart;
        end

        kwm_cell #(
            .KMER_BITS (KMER_BITS),
            .POS_BITS  (POS_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .head_value (new_value),
            .prev_value (link_value[i]),
            .prev_pmin  (link_pmin[i]),
            .prev_pos   (link_pos[i]),
            .prev_valid (link_valid[i]),
            .prev_sent  (link_sent[i]),
            .mark       (mark_vec[i]),
            .value      (cell_value[i]),
            .pmin       (cell_pmin[i]),
            .pos        (cell_pos[i]),
            .valid      (valid_vec[i]),
            .sent       (sent_vec[i])
        );
    end

    // seed selection
    always_comb
    begin
        w_eff  = WW'(eff_window(window_size_reg, MAX_WINDOW));
        w_idx  = IDX_W'(w_eff - WW'(1));
        wmin   = cell_pmin[w_idx];
        for (int i = 0; i < MAX_WINDOW; i++)
            eq[i] = (i < int'(w_eff)) && (cell_value[i] == wmin);
        eq_low = eq & (~eq + MAX_WINDOW'(1));

        sel_next = '0;
        if ((select_mode_reg == MODE_FIXED) || (w_eff == WW'(1)))
        begin
            if (hit_reg)
                sel_next = MAX_WINDOW'(1);
        end
        else if (valid_vec[w_idx])
        begin
            if (select_mode_reg == MODE_MIN_RIGHT)
                sel_next = eq_low;
            else
                sel_next = eq;
        end
        else if (en_reg && short_ok_reg)
        begin
            sel_next = MAX_WINDOW'(1) << short_idx_reg;
        end

        cand     = sel_reg & ~sent_vec;
        pick_idx = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
            if (cand[i])
                pick_idx = IDX_W'(i);
    end

    assign out_free  = ~out_valid_reg | seed.ready;
    assign emit      = (state_reg == ST_SCAN) & (cand != '0) & out_free;
    assign emit_last = ~|(cand & (cand - MAX_WINDOW'(1)));
    assign mark_vec  = emit ? (MAX_WINDOW'(1) << pick_idx) : '0;

    // control
    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg & ~seed.ready;
        if (emit)
            out_valid_next = 1'b1;
        if (kmer_acc)
            open_next = ~kmer.ends_sequence;

        case (state_reg)
            ST_IDLE:
            begin
                if (kmer_acc)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((cand == '0) || (emit && emit_last))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kmer_acc)
        begin
            en_reg        <= kmer.ends_sequence;
            hit_reg       <= phase_stat.hit;
            short_ok_reg  <= (item_pos < POS_BITS'(MAX_WINDOW));
            short_idx_reg <= item_pos[IDX_W-1:0];
        end
        if (state_reg == ST_EVAL)
            sel_reg <= sel_next;
        if (emit)
        begin
            seed_value_reg    <= KMER_W'(cell_value[pick_idx]);
            seed_position_reg <= POS_W'(cell_pos[pick_idx]);
            seed_last_reg     <= emit_last;
        end
    end

    assign seed.valid         = out_valid_reg;
    assign seed.seed_value    = seed_value_reg;
    assign seed.seed_position = seed_position_reg;
    assign seed.last_of_run   = seed_last_reg;

    // checks
    a_acc_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        kmer_acc |=> (state_reg == ST_EVAL))
        else $error("accepted request did not move to evaluation");

    a_cand_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((cand & ~valid_vec) == '0))
        else $error("seed candidate in an empty window cell");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("scan continued after last seed");

endmodule

`default_nettype wire

### tb/sv/kwm_seed_checker.sv
// Seed checker for the k-mer window minimizer select unit: watches the k-mer,
// seed and register channels, predicts the seeds of each request and compares.
// Depends on kwm_pkg and the channel interfaces in kwm_ifs.
`default_nettype none

module kwm_seed_checker (
    input wire logic clk,
    input wire logic rst_n,
    kwm_kmer_if      kmer,
    kwm_seed_if      seed,
    kwm_cfg_if       cfg,
    output int       mismatches,
    output int       seeds_pending,
    output int       seeds_matched
);
    import kwm_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [KMER_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic              last;
    } seed_t;

    seed_t seeds_due[$];
    seed_t run_seeds[$];

    logic [KMER_W-1:0]  win_value [MAX_WINDOW_DEF];
    logic [POS_W-1:0]   win_pos   [MAX_WINDOW_DEF];
    bit                 win_full  [MAX_WINDOW_DEF];
    bit                 win_sent  [MAX_WINDOW_DEF];
    logic [POS_W-1:0]   next_pos;
    bit                 seq_open;
    logic [KLEN_W-1:0]  klen;
    logic [WSIZE_W-1:0] wsize;
    logic [MODE_W-1:0]  mode;

    int fail_total = 0;
    int reported   = 0;
    int seeds_ok   = 0;

    function automatic void clear_window();
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
        begin
            win_value[i] = '0;
            win_pos[i]   = '0;
            win_full[i]  = 1'b0;
            win_sent[i]  = 1'b0;
        end
    endfunction

    function automatic void take_slot(int slot);
        seed_t s;
        s.value    = win_value[slot];
        s.position = win_pos[slot];
        s.last     = 1'b0;
        run_seeds.push_back(s);
        win_sent[slot] = 1'b1;
    endfunction

    function automatic void predict_seeds(logic [KMER_W-1:0] v, logic st, logic en);
        int                k;
        int                w;
        int                i;
        int                hit;
        logic [KMER_W-1:0] low;
        logic [POS_W-1:0]  pos;
        seed_t             s;
        k = (klen == '0) ? 1 : int'(klen);
        w = (wsize == '0) ? 1 : int'(wsize);
        if (w > MAX_WINDOW_DEF)
            w = MAX_WINDOW_DEF;
        run_seeds.delete();

        if (st || !seq_open)
        begin
            clear_window();
            next_pos = '0;
            seq_open = 1'b1;
        end
        pos = next_pos;

        for (i = MAX_WINDOW_DEF - 1; i > 0; i--)
        begin
            win_value[i] = win_value[i-1];
            win_pos[i]   = win_pos[i-1];
            win_full[i]  = win_full[i-1];
            win_sent[i]  = win_sent[i-1];
        end
        win_value[0] = v;
        win_pos[0]   = pos;
        win_full[0]  = 1'b1;
        win_sent[0]  = 1'b0;

        if (mode == MODE_FIXED || w == 1)
        begin
            if (((64'(pos) + 64'(k) - 64'd1) % 64'(w)) == 64'd0)
                take_slot(0);
        end
        else if (win_full[w-1])
        begin
            low = win_value[0];
            for (i = 1; i < w; i++)
                if (win_value[i] < low)
                    low = win_value[i];
            if (mode == MODE_MIN_RIGHT)
            begin
                hit = 0;
                while (win_value[hit] != low)
                    hit++;
                if (!win_sent[hit])
                    take_slot(hit);
            end
            else
            begin
                for (i = w - 1; i >= 0; i--)
                    if (win_value[i] == low && !win_sent[i])
                        take_slot(i);
            end
        end
        else if (en)
        begin
            if (pos < MAX_WINDOW_DEF && win_full[pos] && !win_sent[pos])
                take_slot(int'(pos));
        end

        for (i = 0; i < run_seeds.size(); i++)
        begin
            s = run_seeds[i];
            s.last = (i == run_seeds.size() - 1);
            seeds_due.push_back(s);
        end

        if (en)
            seq_open = 1'b0;
        next_pos = pos + 1'b1;
    endfunction

    function automatic void check_seed();
        seed_t got;
        seed_t want;
        got.value    = seed.seed_value;
        got.position = seed.seed_position;
        got.last     = seed.last_of_run;
        if (seeds_due.size() == 0)
        begin
            fail_total++;
            if (reported < MAX_REPORTS)
                $display("unexpected seed: value=%h position=%0d last=%0b",
                         got.value, got.position, got.last);
            reported++;
        end
        else
        begin
            want = seeds_due.pop_front();
            if (got.value !== want.value || got.position !== want.position ||
                got.last !== want.last)
            begin
                fail_total++;
                if (reported < MAX_REPORTS)
                    $display("seed mismatch: expected value=%h position=%0d last=%0b,",
                             want.value, want.position, want.last,
                             " got value=%h position=%0d last=%0b",
                             got.value, got.position, got.last);
                reported++;
            end
            else
                seeds_ok++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            next_pos = '0;
            seq_open = 1'b0;
            klen     = KLEN_RST;
            wsize    = WSIZE_RST;
            mode     = MODE_MIN_RIGHT;
            seeds_due.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KMER_LENGTH: klen  = cfg.data[KLEN_W-1:0];
                    REG_WINDOW_SIZE: wsize = cfg.data[WSIZE_W-1:0];
                    REG_SELECT_MODE: mode  = cfg.data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (kmer.valid && kmer.ready)
                predict_seeds(kmer.kmer_value, kmer.starts_sequence, kmer.ends_sequence);
            if (seed.valid && seed.ready)
                check_seed();
        end
        mismatches    <= fail_total;
        seeds_pending <= seeds_due.size();
        seeds_matched <= seeds_ok;
    end

endmodule

`default_nettype wire

### tb/sv/kmer_window_minimizer_select_unit_tb.sv
// Testbench top for the k-mer window minimizer select unit: drives k-mer requests and
// register writes across idling phases and settings; kwm_seed_checker does the checking.
// Depends on kwm_pkg, kwm_ifs, the unit and kwm_seed_checker.
`default_nettype none

module kmer_window_minimizer_select_unit_tb;
    import kwm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 36;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 48;
    localparam int HOLD_CYCLES   = 250;
    localparam int RAND_CFG      = -1;

    logic clk;
    logic rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int items_sent     = 0;
    int reg_writes     = 0;
    int cur_window     = 16;
    int mismatches;
    int seeds_pending;
    int seeds_matched;

    int kcfg [PHASES] = '{0, 1, 32, 63, 5, 7, 3, RAND_CFG, 32, RAND_CFG, RAND_CFG, 16};
    int wcfg [PHASES] = '{0, 2, 5, 8, 32, 63, 3, RAND_CFG, 1, 33, RAND_CFG, 16};
    int mcfg [PHASES] = '{MODE_MIN_RIGHT, MODE_MIN_RIGHT, MODE_MIN_ALL, MODE_FIXED,
                          MODE_MIN_RIGHT, MODE_MIN_ALL, MODE_UNUSED, RAND_CFG,
                          MODE_MIN_ALL, MODE_FIXED, RAND_CFG, MODE_MIN_RIGHT};
    int idle_pct  [4] = '{0, 68, 0, 10};
    int stall_pct [4] = '{0, 0, 68, 10};

    kwm_kmer_if kmer_ch ();
    kwm_seed_if seed_ch ();
    kwm_cfg_if  cfg_ch ();

    kmer_window_minimizer_select_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .kmer  (kmer_ch),
        .seed  (seed_ch),
        .cfg   (cfg_ch)
    );

    kwm_seed_checker seed_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .kmer          (kmer_ch),
        .seed          (seed_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .seeds_pending (seeds_pending),
        .seeds_matched (seeds_matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd30_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        seed_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                seed_ch.ready <= 1'b0;
            end
            else
                seed_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [KMER_W-1:0] pick_kmer(int style);
        case (style)
            0: return {$urandom, $urandom};
            1: return KMER_W'($urandom_range(3));
            2:
            begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return {32'hFFFF_FFFF, 30'd0, 2'($urandom_range(3))};
                    default: return {$urandom_range(1) == 1, 61'd0, 2'($urandom_range(3))};
                endcase
            end
            default: return {2'($urandom_range(3)), 58'd0, 4'($urandom_range(15))};
        endcase
    endfunction

    task automatic send_kmer(logic [KMER_W-1:0] v, logic st, logic en);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            kmer_ch.valid <= 1'b0;
            @(negedge clk);
        end
        kmer_ch.valid           <= 1'b1;
        kmer_ch.kmer_value      <= v;
        kmer_ch.starts_sequence <= st;
        kmer_ch.ends_sequence   <= en;
        @(posedge clk);
        while (!kmer_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic release_kmer();
        @(negedge clk);
        kmer_ch.valid <= 1'b0;
    endtask

    task automatic send_sequence(int len, int style, logic closed);
        for (int i = 0; i < len; i++)
            send_kmer(pick_kmer(style), i == 0, closed && i == len - 1);
    endtask

    task automatic settle();
        release_kmer();
        while (seeds_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reg_writes++;
    endtask

    task automatic configure(int k, int w, logic [MODE_W-1:0] m);
        settle();
        write_reg(REG_KMER_LENGTH, CFG_DATA_W'(k));
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(w));
        write_reg(REG_SELECT_MODE, CFG_DATA_W'(m));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_window = (w == 0) ? 1 : (w > MAX_WINDOW_DEF ? MAX_WINDOW_DEF : w);
    endtask

    task automatic run_random(int budget);
        int left;
        int len;
        int style;
        int kind;
        left = budget;
        while (left > 0)
        begin
            kind  = $urandom_range(9);
            style = $urandom_range(3);
            case ($urandom_range(3))
                0: len = $urandom_range(1, 3);
                1: len = $urandom_range(cur_window > 1 ? cur_window - 1 : 1, cur_window + 1);
                2: len = $urandom_range(cur_window, 2 * cur_window + 8);
                default: len = $urandom_range(1, 40);
            endcase
            if (len > left + 8)
                len = left + 8;
            if (kind == 0)
            begin
                send_kmer(pick_kmer(style), $urandom_range(3) == 0, $urandom_range(3) == 0);
                left--;
            end
            else
            begin
                // drop the end mark now and then so a sequence is left open when the next run starts
                send_sequence(len, style, kind != 1);
                left -= len;
            end
        end
    endtask

    initial
    begin
        int k;
        int w;
        logic [MODE_W-1:0] m;
        rst_n                   = 1'b0;
        kmer_ch.valid           = 1'b0;
        kmer_ch.kmer_value      = '0;
        kmer_ch.starts_sequence = 1'b0;
        kmer_ch.ends_sequence   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_KMER_LENGTH;
        cfg_ch.data             = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // open a sequence without a start mark, end it short of a full window
        send_kmer('1, 1'b0, 1'b0);
        send_kmer(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        send_kmer('0, 1'b0, 1'b1);
        send_kmer('0, 1'b1, 1'b1);

        configure(1, 3, MODE_MIN_ALL);
        send_kmer(64'd5, 1'b1, 1'b0);
        send_kmer(64'd5, 1'b0, 1'b0);
        send_kmer(64'd5, 1'b0, 1'b0);
        send_kmer(64'd7, 1'b0, 1'b0);
        send_kmer(64'd5, 1'b0, 1'b0);
        send_kmer(64'd0, 1'b0, 1'b0);
        send_kmer(64'd0, 1'b0, 1'b1);

        configure(3, 4, MODE_FIXED);
        for (int i = 0; i < 8; i++)
            send_kmer((i % 2 == 1) ? '1 : '0, i == 0, i == 7);

        configure(2, 3, MODE_MIN_RIGHT);
        send_kmer(64'd9, 1'b1, 1'b0);
        send_kmer(64'd9, 1'b0, 1'b0);
        send_kmer(64'd9, 1'b0, 1'b0);
        send_kmer(64'd9, 1'b0, 1'b0);
        send_kmer(64'd3, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            k = (kcfg[p] == RAND_CFG) ? $urandom_range(63) : kcfg[p];
            w = (wcfg[p] == RAND_CFG) ? $urandom_range(1, 12) : wcfg[p];
            m = (mcfg[p] == RAND_CFG) ? MODE_W'($urandom_range(3)) : MODE_W'(mcfg[p]);
            configure(k, w, m);
            send_idle_pct  = idle_pct[p % 4];
            recv_stall_pct = stall_pct[p % 4];
            // hold the seed side off long enough for the unit to back up
            if (p == 0)
                hold_asks++;
            run_random(PHASE_ITEMS);
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        release_kmer();
        while (seeds_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d k-mer requests and %0d register writes over %0d settings;",
                 items_sent, reg_writes, PHASES + 4);
        $display("%0d seeds matched, %0d mismatches, %0d seeds still owed.",
                 seeds_matched, mismatches, seeds_pending);
        if (mismatches == 0 && seeds_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/kwm_pkg.sv
hdl/kwm_ifs.sv
hdl/kwm_cell.sv
hdl/kwm_phase.sv
hdl/kmer_window_minimizer_select_unit.sv
tb/sv/kwm_seed_checker.sv
tb/sv/kmer_window_minimizer_select_unit_tb.sv
